// File: rtl/jsf_pkg.sv
// ----------------------------------------------------------------------------
// jsf_pkg
// Shared types and constants for the JSON object stream framer.
// ----------------------------------------------------------------------------
package jsf_pkg;

  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int MODE_W    = 3;

  // scanner mode codes; the two spare codes behave as outside
  localparam logic [MODE_W-1:0] MODE_OUT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OBJ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DQ    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DQESC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SQ    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SQESC = 3'd5;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       chunk_end;
  } jsf_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       keep;
    logic       frame_first;
    logic       frame_last;
    logic       depth_overflow;
    logic       chunk_end_out;
  } jsf_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DEPTH_W-1:0] depth;
  } jsf_state_t;

endpackage

// File: rtl/json_object_stream_framer.sv
// ----------------------------------------------------------------------------
// json_object_stream_framer
// Marks top-level brace-balanced objects in a byte stream, one byte per clock while in_ready is high.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------
//  input   | in_valid, in_ready, in_data    | jsf_in_t  (byte, chunk end)
//  result  | out_valid, out_ready, out_data | jsf_out_t (byte and marks)
//
//  One transfer in, one transfer out; a byte is accepted every clock while in_ready
//  is high, and its result is registered in the output register, or in the skid register while the output stalls.
//  The scanner update is one pass of jsf_scan between the state registers.
//  A stalled output parks one further result in a skid register; in_ready
//  drops only while that skid register is full.
//  rst_n (synchronous) returns the scanner to outside with depth 0.
// ----------------------------------------------------------------------------
module json_object_stream_framer import jsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jsf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jsf_out_t out_data
);

  jsf_state_t state_r;
  jsf_state_t state_nxt;
  jsf_out_t   res;
  jsf_out_t   out_r;
  jsf_out_t   skid_r;
  logic       out_valid_r;
  logic       skid_valid_r;
  logic       in_fire;
  logic       out_free;

  jsf_scan u_scan (
    .cur (state_r),
    .din (in_data),
    .nxt (state_nxt),
    .res (res)
  );

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode  <= MODE_OUT;
      state_r.depth <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/jsf_scan.sv
// ----------------------------------------------------------------------------
// jsf_scan
// Next-state and result logic of the brace-balancing scanner for one byte.
// ----------------------------------------------------------------------------
module jsf_scan import jsf_pkg::*; (
  input  jsf_state_t cur,
  input  jsf_in_t    din,
  output jsf_state_t nxt,
  output jsf_out_t   res
);

  logic [7:0] b;
  logic       keep;
  logic       first;
  logic       last;
  logic       ovf;

  assign b = din.byte_in;

  always_comb begin
    nxt   = cur;
    keep  = 1'b0;
    first = 1'b0;
    last  = 1'b0;
    ovf   = 1'b0;
    case (cur.mode)
      MODE_OBJ: begin
        keep = 1'b1;
        if (b == CH_LBRACE) begin
          if (cur.depth >= DEPTH_W'(MAX_DEPTH)) begin
            nxt.depth = DEPTH_W'(MAX_DEPTH);
            ovf       = 1'b1;
          end else begin
            nxt.depth = cur.depth + DEPTH_W'(1);
          end
        end else if (b == CH_RBRACE) begin
          if (cur.depth <= DEPTH_W'(1)) begin
            nxt.depth = '0;
            nxt.mode  = MODE_OUT;
            last      = 1'b1;
          end else begin
            nxt.depth = cur.depth - DEPTH_W'(1);
          end
        end else if (b == CH_DQUOTE) begin
          nxt.mode = MODE_DQ;
        end else if (b == CH_SQUOTE) begin
          nxt.mode = MODE_SQ;
        end
      end
      MODE_DQ: begin
        keep = 1'b1;
        if (b == CH_BACKSLASH) begin
          nxt.mode = MODE_DQESC;
        end else if (b == CH_DQUOTE) begin
          nxt.mode = MODE_OBJ;
        end
      end
      MODE_DQESC: begin
        keep     = 1'b1;
        nxt.mode = MODE_DQ;
      end
      MODE_SQ: begin
        keep = 1'b1;
        if (b == CH_BACKSLASH) begin
          nxt.mode = MODE_SQESC;
        end else if (b == CH_SQUOTE) begin
          nxt.mode = MODE_OBJ;
        end
      end
      MODE_SQESC: begin
        keep     = 1'b1;
        nxt.mode = MODE_SQ;
      end
      default: begin
        // outside an object: only an opening brace starts a frame
        nxt.mode  = MODE_OUT;
        nxt.depth = '0;
        if (b == CH_LBRACE) begin
          keep      = 1'b1;
          first     = 1'b1;
          nxt.depth = DEPTH_W'(1);
          nxt.mode  = MODE_OBJ;
        end
      end
    endcase
  end

  assign res.byte_out       = b;
  assign res.keep           = keep;
  assign res.frame_first    = first;
  assign res.frame_last     = last;
  assign res.depth_overflow = ovf;
  assign res.chunk_end_out  = din.chunk_end;

endmodule

// File: rtl/jsf_checker.sv
// ----------------------------------------------------------------------------
// jsf_port_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
module jsf_port_checker import jsf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input jsf_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // dropped bytes carry no marks
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.keep |->
      !out_data.frame_first && !out_data.frame_last && !out_data.depth_overflow)
    else $error("mark set on a dropped byte");

  // opening marks sit on an opening brace
  a_open_brace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.frame_first || out_data.depth_overflow) |->
      out_data.byte_out == CH_LBRACE && out_data.keep)
    else $error("opening mark on a byte other than an opening brace");

  // a frame closes on a closing brace, never on the byte that opens it
  a_close_brace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_last |->
      out_data.byte_out == CH_RBRACE && !out_data.frame_first)
    else $error("closing mark on a wrong byte");

  // nothing is shown straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind json_object_stream_framer jsf_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: verif/jsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_checker
// Watches both channels of the framer, predicts the marks of each byte from
// its own scanner copy and compares every result transfer, in order.
// ----------------------------------------------------------------------------
module jsf_checker import jsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  jsf_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  jsf_out_t out_data,
  output int       mismatches,
  output int       outstanding
);

  logic [MODE_W-1:0]  scan_mode;
  logic [DEPTH_W-1:0] nest_depth;
  jsf_out_t           framed_q[$];

  // advances the scanner copy by one byte and returns the marked byte
  function automatic jsf_out_t mark_byte(input jsf_in_t it);
    jsf_out_t r;
    r = '0;
    r.byte_out      = it.byte_in;
    r.chunk_end_out = it.chunk_end;
    case (scan_mode)
      MODE_OBJ: begin
        r.keep = 1'b1;
        if (it.byte_in == CH_LBRACE) begin
          if (nest_depth >= DEPTH_W'(MAX_DEPTH)) begin
            nest_depth       = DEPTH_W'(MAX_DEPTH);
            r.depth_overflow = 1'b1;
          end else begin
            nest_depth = nest_depth + 1'b1;
          end
        end else if (it.byte_in == CH_RBRACE) begin
          if (nest_depth <= 1) begin
            nest_depth   = '0;
            scan_mode    = MODE_OUT;
            r.frame_last = 1'b1;
          end else begin
            nest_depth = nest_depth - 1'b1;
          end
        end else if (it.byte_in == CH_DQUOTE) begin
          scan_mode = MODE_DQ;
        end else if (it.byte_in == CH_SQUOTE) begin
          scan_mode = MODE_SQ;
        end
      end
      MODE_DQ: begin
        r.keep = 1'b1;
        if (it.byte_in == CH_BACKSLASH) scan_mode = MODE_DQESC;
        else if (it.byte_in == CH_DQUOTE) scan_mode = MODE_OBJ;
      end
      MODE_DQESC: begin
        r.keep    = 1'b1;
        scan_mode = MODE_DQ;
      end
      MODE_SQ: begin
        r.keep = 1'b1;
        if (it.byte_in == CH_BACKSLASH) scan_mode = MODE_SQESC;
        else if (it.byte_in == CH_SQUOTE) scan_mode = MODE_OBJ;
      end
      MODE_SQESC: begin
        r.keep    = 1'b1;
        scan_mode = MODE_SQ;
      end
      default: begin
        // spare codes fall back to outside as well
        scan_mode  = MODE_OUT;
        nest_depth = '0;
        if (it.byte_in == CH_LBRACE) begin
          r.keep        = 1'b1;
          r.frame_first = 1'b1;
          nest_depth    = DEPTH_W'(1);
          scan_mode     = MODE_OBJ;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    jsf_out_t want;
    if (!rst_n) begin
      scan_mode  = MODE_OUT;
      nest_depth = '0;
      framed_q.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // result first: it always belongs to an earlier input transfer
      if (out_valid && out_ready) begin
        if (framed_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t unexpected: byte=%02h keep=%b first=%b last=%b ovf=%b ce=%b",
                     $time, out_data.byte_out, out_data.keep, out_data.frame_first,
                     out_data.frame_last, out_data.depth_overflow, out_data.chunk_end_out);
          mismatches <= mismatches + 1;
        end else begin
          want = framed_q.pop_front();
          if (out_data.byte_out       !== want.byte_out    ||
              out_data.keep           !== want.keep        ||
              out_data.frame_first    !== want.frame_first ||
              out_data.frame_last     !== want.frame_last  ||
              out_data.depth_overflow !== want.depth_overflow ||
              out_data.chunk_end_out  !== want.chunk_end_out) begin
            if (mismatches < 10) begin
              $display("%0t mismatch: exp byte=%02h keep=%b first=%b last=%b ovf=%b ce=%b",
                       $time, want.byte_out, want.keep, want.frame_first,
                       want.frame_last, want.depth_overflow, want.chunk_end_out);
              $display("%0t           got byte=%02h keep=%b first=%b last=%b ovf=%b ce=%b",
                       $time, out_data.byte_out, out_data.keep, out_data.frame_first,
                       out_data.frame_last, out_data.depth_overflow,
                       out_data.chunk_end_out);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        framed_q.push_back(mark_byte(in_data));
      outstanding <= framed_q.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte stream stimulus for the object framer: directed corner bytes, then
// random objects with nested braces, quoted strings and escapes, stray and
// missing braces, noise and one frame deep enough to saturate the depth.
// ----------------------------------------------------------------------------
module tb;
  import jsf_pkg::*;

  localparam int STREAM_BYTES = 900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DEEP_OPENS   = MAX_DEPTH + 2;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  jsf_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  jsf_out_t out_data;

  int mismatches;
  int outstanding;
  int bytes_sent = 0;
  int cycles     = 0;
  bit idle_en    = 1'b1;
  bit deep_done  = 1'b0;
  bit drained    = 1'b0;

  always #5 clk = ~clk;

  json_object_stream_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  jsf_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // receiver back-pressure
  always @(posedge clk)
    out_ready <= idle_en ? ($urandom_range(0, 99) >= 30) : 1'b1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic rand_chunk_end();
    return $urandom_range(0, 7) == 0;
  endfunction

  // any byte the scanner treats as ordinary text
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_LBRACE || b == CH_RBRACE || b == CH_DQUOTE ||
           b == CH_SQUOTE || b == CH_BACKSLASH);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic ce);
    while (idle_en && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_in: b, chunk_end: ce};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_quoted(input logic [7:0] q);
    logic [7:0] b;
    send_byte(q, rand_chunk_end());
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_byte(CH_BACKSLASH, rand_chunk_end());
        send_byte(8'($urandom_range(0, 255)), rand_chunk_end());
      end else begin
        // braces and the other quote are just text here
        do b = 8'($urandom_range(0, 255));
        while (b == q || b == CH_BACKSLASH);
        send_byte(b, rand_chunk_end());
      end
    end
    send_byte(q, rand_chunk_end());
  endtask

  // closes is added to the open depth: negative leaves the object open,
  // positive sends stray braces after it
  task automatic send_object(input int max_nest, input int closes);
    int d;
    d = 1;
    send_byte(CH_LBRACE, rand_chunk_end());
    repeat ($urandom_range(1, 20)) begin
      case ($urandom_range(0, 5))
        0: if (d < max_nest) begin
          send_byte(CH_LBRACE, rand_chunk_end());
          d++;
        end
        1: if (d > 1) begin
          send_byte(CH_RBRACE, rand_chunk_end());
          d--;
        end
        2: send_quoted(CH_DQUOTE);
        3: send_quoted(CH_SQUOTE);
        default: send_byte(plain_byte(), rand_chunk_end());
      endcase
    end
    repeat (d + closes) send_byte(CH_RBRACE, rand_chunk_end());
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) send_byte(plain_byte(), rand_chunk_end());
      else send_byte(8'($urandom_range(0, 255)), rand_chunk_end());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // outside an object: everything but an opening brace is dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(CH_RBRACE, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_BACKSLASH, 1'b1);
    // braces and escapes inside both kinds of string
    send_byte(CH_LBRACE, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_LBRACE, 1'b1);
    send_byte(CH_BACKSLASH, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_RBRACE, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(CH_BACKSLASH, 1'b0);
    send_byte(CH_SQUOTE, 1'b1);
    send_byte(CH_RBRACE, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    // nesting, then a close back to depth zero
    send_byte(CH_LBRACE, 1'b0);
    send_byte(CH_RBRACE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(CH_RBRACE, 1'b0);
    send_byte(CH_LBRACE, 1'b1);
    send_byte(CH_RBRACE, 1'b1);

    while (bytes_sent < STREAM_BYTES) begin
      // a clean stretch where neither side idles
      idle_en = !(bytes_sent >= 300 && bytes_sent < 450);
      if (!deep_done && bytes_sent >= 450) begin
        // saturate the depth; the frame then closes early on the way down
        repeat (DEEP_OPENS) send_byte(CH_LBRACE, rand_chunk_end());
        send_quoted(CH_DQUOTE);
        repeat (DEEP_OPENS) send_byte(CH_RBRACE, rand_chunk_end());
        deep_done = 1'b1;
      end else if (!drained && bytes_sent >= 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        drained = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_object($urandom_range(1, 6), 0);
          6:                send_object($urandom_range(1, 6), $urandom_range(1, 2));
          7:                send_object($urandom_range(2, 6), -1);
          default:          send_noise($urandom_range(1, 10));
        endcase
      end
    end

    in_valid <= 1'b0;
    idle_en = 1'b1;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
